@@ src/audio_frame_cadence_rechunker_defines.svh @@
// Assertion macros for the audio frame cadence rechunker.
// Each macro gives one labeled concurrent assertion, clocked on the rising edge
// and disabled while the active-low reset is asserted.
`ifndef AUDIO_FRAME_CADENCE_RECHUNKER_DEFINES_SVH
`define AUDIO_FRAME_CADENCE_RECHUNKER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define AFCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("afcr: implication check failed");

// Next-cycle implication
`define AFCR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("afcr: next-cycle check failed");

`else

`define AFCR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AFCR_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/afcr_pkg.sv @@
// ----------------------------------------------------------------------------
// afcr_pkg
// Shared widths, constants, controller states and the command and status
// bundles between the rechunker controller and datapath.
// ----------------------------------------------------------------------------
package afcr_pkg;

	// Payload and framing widths
	localparam int WORD_BITS   = 32;
	localparam int SAMPLE_BITS = 32;
	localparam int FRAME_BITS  = 20;
	localparam int LEN_BITS    = 20;

	// Configuration widths
	localparam int FIXED_BITS     = 20;
	localparam int RATE_BITS      = 20;
	localparam int NUM_BITS       = 17;
	localparam int DEN_BITS       = 10;
	localparam int CFG_DATA_BITS  = 20;
	localparam int CFG_INDEX_BITS = 2;

	// Remainder and division widths
	localparam int REM_BITS   = 18;
	localparam int TOTAL_BITS = RATE_BITS + DEN_BITS + 1;
	localparam int ACC_BITS   = NUM_BITS + 1;
	localparam int STEP_BITS  = $clog2(TOTAL_BITS);
	localparam int USED_BITS  = FRAME_BITS + NUM_BITS;
	localparam int CMP_BITS   = (TOTAL_BITS > FRAME_BITS) ? TOTAL_BITS : FRAME_BITS;
	localparam int RCMP_BITS  = (USED_BITS > TOTAL_BITS) ? USED_BITS : TOTAL_BITS;

	localparam logic [STEP_BITS-1:0]  LAST_STEP = STEP_BITS'(TOTAL_BITS - 1);
	localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;
	localparam logic [REM_BITS-1:0]   REM_MAX   = '1;
	localparam logic [FRAME_BITS-1:0] MIN_DERIVED_LEN = FRAME_BITS'(2);
	localparam logic [WORD_BITS-1:0]  SAMPLE_MASK =
		(SAMPLE_BITS >= WORD_BITS) ? '1 : WORD_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

	// Register reset values
	localparam logic [FIXED_BITS-1:0] FIXED_RESET = '0;
	localparam logic [RATE_BITS-1:0]  RATE_RESET  = RATE_BITS'(48000);
	localparam logic [NUM_BITS-1:0]   NUM_RESET   = NUM_BITS'(30000);
	localparam logic [DEN_BITS-1:0]   DEN_RESET   = DEN_BITS'(1001);

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FIXED_LENGTH = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_RATE  = CFG_INDEX_BITS'(1);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RATE_NUM     = CFG_INDEX_BITS'(2);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RATE_DEN     = CFG_INDEX_BITS'(3);

	// Input command codes
	localparam logic CMD_SAMPLE  = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_LEN,
		S_MUL,
		S_FIN
	} afcr_state_t;

	// Controller to datapath
	typedef struct packed {
		logic restart;
		logic emit_in;
		logic load;
		logic div_step;
		logic len_step;
		logic mul_step;
		logic finish;
	} afcr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_free;
	} afcr_status_t;

endpackage

@@ src/afcr_if.sv @@
// ----------------------------------------------------------------------------
// afcr_if
// Channel interfaces of the rechunker: sample input, frame output and
// configuration write.
// ----------------------------------------------------------------------------
interface afcr_sample_if;
	logic                            valid;
	logic                            ready;
	logic                            cmd;
	logic [afcr_pkg::WORD_BITS-1:0] sample_word;

	modport source (output valid, output cmd, output sample_word, input ready);
	modport sink   (input valid, input cmd, input sample_word, output ready);
endinterface

interface afcr_frame_if;
	logic                            valid;
	logic                            ready;
	logic [afcr_pkg::WORD_BITS-1:0] out_sample;
	logic                            last_of_frame;
	logic [afcr_pkg::LEN_BITS-1:0]  frame_length;

	modport source (output valid, output out_sample, output last_of_frame,
		output frame_length, input ready);
	modport sink   (input valid, input out_sample, input last_of_frame,
		input frame_length, output ready);
endinterface

interface afcr_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [afcr_pkg::CFG_INDEX_BITS-1:0] index;
	logic [afcr_pkg::CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/audio_frame_cadence_rechunker.sv @@
// ----------------------------------------------------------------------------
// audio_frame_cadence_rechunker
// Cuts a sample word stream into frames, tagging each word with its frame
// length and a last-of-frame mark; lengths are fixed or follow a video rate.
// ----------------------------------------------------------------------------
//   channel     dir  handshake      payload
//   sample_in   in   valid/ready    cmd, sample_word
//   frame_out   out  valid/ready    out_sample, last_of_frame, frame_length
//   cfg         in   valid/ready    index, data (always ready)
//
// A word inside a frame, or at a fixed-length frame start, goes straight to the output.
// A word that opens a derived-length frame first runs a 31-step bit-serial divide,
// then length, product and remainder steps.
// A restart word gives no result.
// Reset is asynchronous: frame position, remainder and registers take reset values at once.
// A stalled output register holds the next word off until it is taken.
// ----------------------------------------------------------------------------
module audio_frame_cadence_rechunker (
	input  logic         clk,
	input  logic         arst_n,
	afcr_sample_if.sink  sample_in,
	afcr_frame_if.source frame_out,
	afcr_cfg_if.sink     cfg
);

	afcr_pkg::afcr_cmd_t    cmd;
	afcr_pkg::afcr_status_t sts;
	logic                   in_ready;

	assign sample_in.ready = in_ready;

	afcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_in.valid),
		.in_cmd   (sample_in.cmd),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	afcr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_word   (sample_in.sample_word),
		.cfg       (cfg),
		.frame_out (frame_out)
	);

endmodule

@@ src/afcr_datapath.sv @@
// ----------------------------------------------------------------------------
// afcr_datapath
// Configuration registers, frame position, remainder, the bit-serial frame
// length divider and the output word register.
// ----------------------------------------------------------------------------
module afcr_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  afcr_pkg::afcr_cmd_t             cmd,
	output afcr_pkg::afcr_status_t          sts,
	input  logic [afcr_pkg::WORD_BITS-1:0] in_word,
	afcr_cfg_if.sink                        cfg,
	afcr_frame_if.source                    frame_out
);

	logic [afcr_pkg::FIXED_BITS-1:0] fixed_q;
	logic [afcr_pkg::RATE_BITS-1:0]  rate_q;
	logic [afcr_pkg::NUM_BITS-1:0]   num_q;
	logic [afcr_pkg::DEN_BITS-1:0]   den_q;

	logic [afcr_pkg::FRAME_BITS-1:0] pos_q;
	logic [afcr_pkg::FRAME_BITS-1:0] cur_len_q;
	logic [afcr_pkg::REM_BITS-1:0]   rem_q;

	logic [afcr_pkg::WORD_BITS-1:0]  held_word_q;
	logic [afcr_pkg::TOTAL_BITS-1:0] total_q;
	logic [afcr_pkg::TOTAL_BITS-1:0] quo_q;
	logic [afcr_pkg::ACC_BITS-1:0]   acc_q;
	logic [afcr_pkg::STEP_BITS-1:0]  step_q;
	logic [afcr_pkg::FRAME_BITS-1:0] len_q;
	logic [afcr_pkg::USED_BITS-1:0]  used_q;

	logic                            out_valid_q;
	logic [afcr_pkg::WORD_BITS-1:0]  out_word_q;
	logic                            out_last_q;
	logic [afcr_pkg::LEN_BITS-1:0]   out_len_q;

	logic [afcr_pkg::TOTAL_BITS-1:0] total_in;
	logic [afcr_pkg::ACC_BITS-1:0]   trial;
	logic                            trial_ge;
	logic [afcr_pkg::FRAME_BITS-1:0] fixed_len;
	logic [afcr_pkg::CMP_BITS-1:0]   quo_ext;
	logic                            quo_sat;
	logic [afcr_pkg::FRAME_BITS-1:0] len_raw;
	logic [afcr_pkg::FRAME_BITS-1:0] len_even;
	logic [afcr_pkg::FRAME_BITS-1:0] len_derived;
	logic [afcr_pkg::RCMP_BITS-1:0]  used_ext;
	logic [afcr_pkg::RCMP_BITS-1:0]  total_ext;
	logic [afcr_pkg::RCMP_BITS-1:0]  diff;
	logic [afcr_pkg::REM_BITS-1:0]   rem_next;
	logic                            emit;
	logic [afcr_pkg::FRAME_BITS-1:0] emit_len;
	logic [afcr_pkg::WORD_BITS-1:0]  emit_word;
	logic [afcr_pkg::FRAME_BITS:0]   pos_inc;
	logic                            emit_last;

	assign cfg.ready = 1'b1;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_q <= afcr_pkg::FIXED_RESET;
			rate_q  <= afcr_pkg::RATE_RESET;
			num_q   <= afcr_pkg::NUM_RESET;
			den_q   <= afcr_pkg::DEN_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				afcr_pkg::CFG_FIXED_LENGTH: fixed_q <= afcr_pkg::FIXED_BITS'(cfg.data);
				afcr_pkg::CFG_SAMPLE_RATE:  rate_q  <= afcr_pkg::RATE_BITS'(cfg.data);
				afcr_pkg::CFG_RATE_NUM:     num_q   <= afcr_pkg::NUM_BITS'(cfg.data);
				afcr_pkg::CFG_RATE_DEN:     den_q   <= afcr_pkg::DEN_BITS'(cfg.data);
				default: ;
			endcase
		end
	end

	// Dividend: sample_rate * rate_den plus the carried remainder
	assign total_in = afcr_pkg::TOTAL_BITS'(rate_q * den_q) + afcr_pkg::TOTAL_BITS'(rem_q);

	// One restoring divide step: shift in the next dividend bit, subtract if it fits
	assign trial    = {acc_q[afcr_pkg::NUM_BITS-1:0], quo_q[afcr_pkg::TOTAL_BITS-1]};
	assign trial_ge = trial >= afcr_pkg::ACC_BITS'(num_q);

	// Fixed length, saturated to the frame counter range
	assign fixed_len = (afcr_pkg::CMP_BITS'(fixed_q) > afcr_pkg::CMP_BITS'(afcr_pkg::FRAME_MAX))
		? afcr_pkg::FRAME_MAX : afcr_pkg::FRAME_BITS'(fixed_q);

	// Derived length: saturate, round down to even, never below two
	assign quo_ext     = afcr_pkg::CMP_BITS'(quo_q);
	assign quo_sat     = (num_q == '0) ||
		(quo_ext > afcr_pkg::CMP_BITS'(afcr_pkg::FRAME_MAX));
	assign len_raw     = quo_sat ? afcr_pkg::FRAME_MAX : afcr_pkg::FRAME_BITS'(quo_ext);
	assign len_even    = {len_raw[afcr_pkg::FRAME_BITS-1:1], 1'b0};
	assign len_derived = (len_even == '0) ? afcr_pkg::MIN_DERIVED_LEN : len_even;

	// Remainder carried forward, clamped to its range
	assign used_ext  = afcr_pkg::RCMP_BITS'(used_q);
	assign total_ext = afcr_pkg::RCMP_BITS'(total_q);
	assign diff      = total_ext - used_ext;
	always_comb begin
		if (used_ext > total_ext) begin
			rem_next = '0;
		end else if (diff > afcr_pkg::RCMP_BITS'(afcr_pkg::REM_MAX)) begin
			rem_next = afcr_pkg::REM_MAX;
		end else begin
			rem_next = afcr_pkg::REM_BITS'(diff);
		end
	end

	// Divider, length and product registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			held_word_q <= in_word;
			total_q     <= total_in;
			quo_q       <= total_in;
			acc_q       <= '0;
			step_q      <= '0;
		end else if (cmd.div_step) begin
			acc_q  <= trial_ge ? (trial - afcr_pkg::ACC_BITS'(num_q)) : trial;
			quo_q  <= {quo_q[afcr_pkg::TOTAL_BITS-2:0], trial_ge};
			step_q <= step_q + 1'b1;
		end
		if (cmd.len_step) begin
			len_q <= len_derived;
		end
		if (cmd.mul_step) begin
			used_q <= afcr_pkg::USED_BITS'(len_q * num_q);
		end
	end

	// Word to emit and its frame tag
	assign emit      = cmd.emit_in || cmd.finish;
	assign emit_len  = cmd.finish ? len_q : ((pos_q == '0) ? fixed_len : cur_len_q);
	assign emit_word = cmd.finish ? held_word_q : in_word;
	assign pos_inc   = {1'b0, pos_q} + 1'b1;
	assign emit_last = pos_inc >= {1'b0, emit_len};

	// Frame position, current length and remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			cur_len_q <= '0;
			rem_q     <= '0;
		end else if (cmd.restart) begin
			pos_q <= '0;
			rem_q <= '0;
		end else if (emit) begin
			pos_q     <= emit_last ? '0 : pos_inc[afcr_pkg::FRAME_BITS-1:0];
			cur_len_q <= emit_len;
			if (cmd.finish) begin
				rem_q <= rem_next;
			end
		end
	end

	// Output word register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (frame_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_word_q <= emit_word & afcr_pkg::SAMPLE_MASK;
			out_last_q <= emit_last;
			out_len_q  <= afcr_pkg::LEN_BITS'(emit_len);
		end
	end

	assign frame_out.valid         = out_valid_q;
	assign frame_out.out_sample    = out_word_q;
	assign frame_out.last_of_frame = out_last_q;
	assign frame_out.frame_length  = out_len_q;

	// Status back to the controller
	assign sts.need_div = (pos_q == '0) && (fixed_q == '0);
	assign sts.div_done = step_q == afcr_pkg::LAST_STEP;
	assign sts.out_free = !out_valid_q || frame_out.ready;

endmodule

@@ src/afcr_ctrl.sv @@
// ----------------------------------------------------------------------------
// afcr_ctrl
// Controller of the rechunker: takes input words, runs the frame length
// divide at each derived frame start and sequences the result into the
// output register.
// ----------------------------------------------------------------------------
`include "audio_frame_cadence_rechunker_defines.svh"

module afcr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_cmd,
	output logic                   in_ready,
	input  afcr_pkg::afcr_status_t sts,
	output afcr_pkg::afcr_cmd_t    cmd
);

	afcr_pkg::afcr_state_t state_q;
	afcr_pkg::afcr_state_t state_next;
	logic                  accept;

	assign in_ready = (state_q == afcr_pkg::S_IDLE) && sts.out_free;
	assign accept   = in_valid && in_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= afcr_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			afcr_pkg::S_IDLE: begin
				if (accept && (in_cmd == afcr_pkg::CMD_SAMPLE) && sts.need_div) begin
					state_next = afcr_pkg::S_DIV;
				end
			end
			afcr_pkg::S_DIV: begin
				if (sts.div_done) begin
					state_next = afcr_pkg::S_LEN;
				end
			end
			afcr_pkg::S_LEN: state_next = afcr_pkg::S_MUL;
			afcr_pkg::S_MUL: state_next = afcr_pkg::S_FIN;
			afcr_pkg::S_FIN: begin
				if (sts.out_free) begin
					state_next = afcr_pkg::S_IDLE;
				end
			end
			default: state_next = afcr_pkg::S_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		case (state_q)
			afcr_pkg::S_IDLE: begin
				if (accept) begin
					if (in_cmd == afcr_pkg::CMD_RESTART) begin
						cmd.restart = 1'b1;
					end else if (sts.need_div) begin
						cmd.load = 1'b1;
					end else begin
						cmd.emit_in = 1'b1;
					end
				end
			end
			afcr_pkg::S_DIV: cmd.div_step = 1'b1;
			afcr_pkg::S_LEN: cmd.len_step = 1'b1;
			afcr_pkg::S_MUL: cmd.mul_step = 1'b1;
			afcr_pkg::S_FIN: cmd.finish   = sts.out_free;
			default: ;
		endcase
	end

	`AFCR_ASSERT_IMP(a_ready_only_idle, clk, arst_n, in_ready, state_q == afcr_pkg::S_IDLE)
	`AFCR_ASSERT_NXT(a_div_starts, clk, arst_n, accept && (in_cmd == afcr_pkg::CMD_SAMPLE) && sts.need_div, state_q == afcr_pkg::S_DIV)
	`AFCR_ASSERT_NXT(a_div_holds, clk, arst_n, (state_q == afcr_pkg::S_DIV) && !sts.div_done, state_q == afcr_pkg::S_DIV)
	`AFCR_ASSERT_NXT(a_fin_returns, clk, arst_n, (state_q == afcr_pkg::S_FIN) && sts.out_free, state_q == afcr_pkg::S_IDLE)

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the audio frame cadence rechunker. A queue-fed
// driver offers sample and restart words, a monitor checks every frame word
// against a framing predictor (position, length and carried remainder), and
// the stimulus walks through fixed, derived, saturated and raw register
// setups with random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned RANDOM_ITEMS  = 1250;
	localparam int unsigned SETTLE_CYCLES = 48;
	localparam int unsigned DRAIN_LIMIT   = 50000;
	localparam int unsigned LONG_HOLD     = 300;

	typedef enum {
		PH_FIXED_SHORT,
		PH_DERIVED_SHORT,
		PH_VIDEO_RATE,
		PH_RAW_REGS,
		PH_BACKPRESSURE
	} phase_kind_t;

	typedef struct {
		logic [afcr_pkg::WORD_BITS-1:0] sample;
		logic                           last;
		logic [afcr_pkg::LEN_BITS-1:0]  len;
	} frame_word_t;

	typedef struct {
		logic                           cmd;
		logic [afcr_pkg::WORD_BITS-1:0] word;
		int unsigned                    gap;
	} sample_item_t;

	logic clk = 1'b0;
	logic arst_n;

	afcr_sample_if sample_bus ();
	afcr_frame_if  frame_bus ();
	afcr_cfg_if    cfg_bus ();

	audio_frame_cadence_rechunker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_in (sample_bus),
		.frame_out (frame_bus),
		.cfg       (cfg_bus)
	);

	// Predictor copy of the registers and framing state
	logic [afcr_pkg::FIXED_BITS-1:0] cfg_fixed = afcr_pkg::FIXED_RESET;
	logic [afcr_pkg::RATE_BITS-1:0]  cfg_rate  = afcr_pkg::RATE_RESET;
	logic [afcr_pkg::NUM_BITS-1:0]   cfg_num   = afcr_pkg::NUM_RESET;
	logic [afcr_pkg::DEN_BITS-1:0]   cfg_den   = afcr_pkg::DEN_RESET;
	logic [afcr_pkg::FRAME_BITS-1:0] pos_in_frame = '0;
	logic [afcr_pkg::LEN_BITS-1:0]   len_of_frame = '0;
	logic [afcr_pkg::REM_BITS-1:0]   carry_rem    = '0;

	sample_item_t outgoing_words[$];
	frame_word_t  pending_frame_words[$];

	int unsigned words_queued  = 0;
	int unsigned words_taken   = 0;
	int unsigned gap_left      = 0;
	int unsigned stall_left    = 0;
	int unsigned hold_left     = 0;
	logic        hold_kick;
	logic        sink_quiet    = 1'b0;
	int unsigned mismatches    = 0;
	int unsigned samples_seen  = 0;
	int unsigned restarts_seen = 0;
	int unsigned frames_closed = 0;
	int unsigned regs_written  = 0;
	int unsigned phases_run    = 0;

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic note_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	// Length of a frame that opens now; updates the carried remainder in derived mode
	function automatic logic [afcr_pkg::LEN_BITS-1:0] next_frame_length();
		longint unsigned total;
		longint unsigned quot;
		longint unsigned len;
		longint unsigned used;
		if (cfg_fixed != '0)
			return afcr_pkg::LEN_BITS'(cfg_fixed);
		total = 64'(cfg_rate) * 64'(cfg_den) + 64'(carry_rem);
		if (cfg_num == '0) begin
			len = 64'(afcr_pkg::FRAME_MAX) & ~64'd1;
		end else begin
			quot = total / 64'(cfg_num);
			len = (quot > 64'(afcr_pkg::FRAME_MAX)) ?
				(64'(afcr_pkg::FRAME_MAX) & ~64'd1) : (quot & ~64'd1);
		end
		// never let a derived frame collapse to nothing
		if (len == 0)
			len = 64'(afcr_pkg::MIN_DERIVED_LEN);
		used = len * 64'(cfg_num);
		if (used > total)
			carry_rem = '0;
		else if (total - used > 64'(afcr_pkg::REM_MAX))
			carry_rem = afcr_pkg::REM_MAX;
		else
			carry_rem = afcr_pkg::REM_BITS'(total - used);
		return afcr_pkg::LEN_BITS'(len);
	endfunction

	// Step the framing state for one accepted word and queue its frame word
	function automatic void advance_framing(input logic cmd,
		input logic [afcr_pkg::WORD_BITS-1:0] word);
		frame_word_t want;
		logic        closes;
		if (cmd == afcr_pkg::CMD_RESTART) begin
			pos_in_frame = '0;
			carry_rem = '0;
			restarts_seen++;
			return;
		end
		if (pos_in_frame == '0)
			len_of_frame = next_frame_length();
		closes = ({1'b0, pos_in_frame} + 1'b1) >= {1'b0, len_of_frame};
		want.sample = word & afcr_pkg::SAMPLE_MASK;
		want.last = closes;
		want.len = len_of_frame;
		pending_frame_words.push_back(want);
		pos_in_frame = closes ? '0 : pos_in_frame + 1'b1;
		samples_seen++;
	endfunction

	// Sample input driver
	always @(posedge clk or negedge arst_n) begin : feed_side
		sample_item_t item;
		if (!arst_n) begin
			sample_bus.valid <= 1'b0;
			sample_bus.cmd <= afcr_pkg::CMD_SAMPLE;
			sample_bus.sample_word <= '0;
			gap_left <= 0;
		end else begin
			// predict the word accepted at this edge
			if (sample_bus.valid && sample_bus.ready) begin
				advance_framing(sample_bus.cmd, sample_bus.sample_word);
				words_taken++;
			end
			// offer the next word once the bus is free and its gap has run out
			if (!sample_bus.valid || sample_bus.ready) begin
				if (gap_left != 0) begin
					sample_bus.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (outgoing_words.size() != 0) begin
					item = outgoing_words.pop_front();
					sample_bus.valid <= 1'b1;
					sample_bus.cmd <= item.cmd;
					sample_bus.sample_word <= item.word;
					gap_left <= item.gap;
				end else begin
					sample_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Long output hold-off, counted down on its own
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_kick) begin
			hold_left <= LONG_HOLD;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Frame output monitor
	always @(posedge clk or negedge arst_n) begin : drain_side
		frame_word_t want;
		int unsigned stall_next;
		if (!arst_n) begin
			frame_bus.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			stall_next = stall_left;
			if (frame_bus.valid && frame_bus.ready) begin
				if (frame_bus.last_of_frame === 1'b1)
					frames_closed++;
				if (pending_frame_words.size() == 0) begin
					note_mismatch($sformatf("unexpected frame word %h", frame_bus.out_sample));
				end else begin
					want = pending_frame_words.pop_front();
					if (frame_bus.out_sample !== want.sample)
						note_mismatch($sformatf("out_sample %h, want %h",
							frame_bus.out_sample, want.sample));
					if (frame_bus.last_of_frame !== want.last)
						note_mismatch($sformatf("last_of_frame %b, want %b (sample %h)",
							frame_bus.last_of_frame, want.last, want.sample));
					if (frame_bus.frame_length !== want.len)
						note_mismatch($sformatf("frame_length %0d, want %0d (sample %h)",
							frame_bus.frame_length, want.len, want.sample));
				end
				stall_next = sink_quiet ? 0 : $urandom_range(0, 9);
			end else if (stall_next != 0) begin
				stall_next--;
			end
			stall_left <= stall_next;
			frame_bus.ready <= (stall_next == 0) && (hold_left == 0);
		end
	end

	// Register writes seen by the predictor
	always @(posedge clk) begin
		if (arst_n && cfg_bus.valid && cfg_bus.ready) begin
			case (cfg_bus.index)
				afcr_pkg::CFG_FIXED_LENGTH: cfg_fixed = afcr_pkg::FIXED_BITS'(cfg_bus.data);
				afcr_pkg::CFG_SAMPLE_RATE:  cfg_rate = afcr_pkg::RATE_BITS'(cfg_bus.data);
				afcr_pkg::CFG_RATE_NUM:     cfg_num = afcr_pkg::NUM_BITS'(cfg_bus.data);
				afcr_pkg::CFG_RATE_DEN:     cfg_den = afcr_pkg::DEN_BITS'(cfg_bus.data);
				default: ;
			endcase
			regs_written++;
		end
	end

	task automatic push_word(input logic cmd, input logic [afcr_pkg::WORD_BITS-1:0] word,
		input int unsigned gap);
		sample_item_t item;
		item.cmd = cmd;
		item.word = word;
		item.gap = gap;
		outgoing_words.push_back(item);
		words_queued++;
	endtask

	task automatic write_reg(input logic [afcr_pkg::CFG_INDEX_BITS-1:0] idx,
		input logic [afcr_pkg::CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic write_all(input logic [afcr_pkg::CFG_DATA_BITS-1:0] fixed_len,
		input logic [afcr_pkg::CFG_DATA_BITS-1:0] rate,
		input logic [afcr_pkg::CFG_DATA_BITS-1:0] num,
		input logic [afcr_pkg::CFG_DATA_BITS-1:0] den);
		write_reg(afcr_pkg::CFG_FIXED_LENGTH, fixed_len);
		write_reg(afcr_pkg::CFG_SAMPLE_RATE, rate);
		write_reg(afcr_pkg::CFG_RATE_NUM, num);
		write_reg(afcr_pkg::CFG_RATE_DEN, den);
	endtask

	// Hold the sender until every word is in and every frame word is out, then settle
	task automatic drain_and_settle();
		int unsigned waited;
		waited = 0;
		while (!(words_taken == words_queued && pending_frame_words.size() == 0)
			&& waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (waited >= DRAIN_LIMIT) begin
			note_mismatch($sformatf("%0d frame words never arrived",
				pending_frame_words.size()));
			pending_frame_words.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input phase_kind_t kind);
		int unsigned count;
		int unsigned pick;
		bit          src_quiet;
		int unsigned rates[4] = '{32000, 44100, 48000, 96000};
		int unsigned nums[5]  = '{30000, 24000, 60000, 25000, 50000};
		int unsigned dens[5]  = '{1001, 1001, 1001, 1000, 1000};
		drain_and_settle();
		src_quiet = ($urandom_range(0, 3) == 0);
		sink_quiet <= ($urandom_range(0, 3) == 0);
		count = $urandom_range(20, 80);
		case (kind)
			PH_FIXED_SHORT: begin
				write_all(afcr_pkg::CFG_DATA_BITS'($urandom_range(1, 12)),
					afcr_pkg::CFG_DATA_BITS'($urandom_range(8000, 768000)),
					afcr_pkg::CFG_DATA_BITS'($urandom_range(1000, 120000)),
					afcr_pkg::CFG_DATA_BITS'($urandom_range(1, 1001)));
			end
			PH_DERIVED_SHORT: begin
				write_all('0, afcr_pkg::CFG_DATA_BITS'($urandom_range(8000, 48000)),
					afcr_pkg::CFG_DATA_BITS'($urandom_range(1000, 120000)),
					afcr_pkg::CFG_DATA_BITS'($urandom_range(1, 4)));
			end
			PH_VIDEO_RATE: begin
				pick = $urandom_range(0, 4);
				write_all('0, afcr_pkg::CFG_DATA_BITS'(rates[$urandom_range(0, 3)]),
					afcr_pkg::CFG_DATA_BITS'(nums[pick]),
					afcr_pkg::CFG_DATA_BITS'(dens[pick]));
			end
			PH_RAW_REGS: begin
				write_all($urandom_range(0, 1) ? afcr_pkg::CFG_DATA_BITS'($urandom) : '0,
					afcr_pkg::CFG_DATA_BITS'($urandom), afcr_pkg::CFG_DATA_BITS'($urandom),
					afcr_pkg::CFG_DATA_BITS'($urandom));
				count = $urandom_range(6, 20);
			end
			PH_BACKPRESSURE: begin
				write_all(afcr_pkg::CFG_DATA_BITS'($urandom_range(1, 6)),
					afcr_pkg::CFG_DATA_BITS'(afcr_pkg::RATE_RESET),
					afcr_pkg::CFG_DATA_BITS'(afcr_pkg::NUM_RESET),
					afcr_pkg::CFG_DATA_BITS'(afcr_pkg::DEN_RESET));
				src_quiet = 1'b1;
				sink_quiet <= 1'b1;
				count = 80;
				// stall the output long enough for the block to back up
				@(posedge clk);
				hold_kick <= 1'b1;
				@(posedge clk);
				hold_kick <= 1'b0;
			end
			default: ;
		endcase
		if ($urandom_range(0, 1) != 0)
			push_word(afcr_pkg::CMD_RESTART, $urandom, src_quiet ? 0 : $urandom_range(0, 9));
		repeat (count) begin
			if (kind != PH_BACKPRESSURE && $urandom_range(0, 15) == 0)
				push_word(afcr_pkg::CMD_RESTART, $urandom,
					src_quiet ? 0 : $urandom_range(0, 9));
			else
				push_word(afcr_pkg::CMD_SAMPLE, $urandom,
					src_quiet ? 0 : $urandom_range(0, 9));
		end
		phases_run++;
	endtask

	// Stimulus
	initial begin
		int unsigned target;
		phase_kind_t kind;
		arst_n = 1'b0;
		hold_kick = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = afcr_pkg::CFG_FIXED_LENGTH;
		cfg_bus.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset registers: derived length from the default video rate
		push_word(afcr_pkg::CMD_SAMPLE, 32'h0000_0000, 0);
		push_word(afcr_pkg::CMD_SAMPLE, 32'hFFFF_FFFF, 1);
		push_word(afcr_pkg::CMD_RESTART, 32'h0000_0000, 0);
		// one-word frames
		drain_and_settle();
		write_reg(afcr_pkg::CFG_FIXED_LENGTH, 20'd1);
		push_word(afcr_pkg::CMD_SAMPLE, 32'hFFFF_FFFF, 0);
		push_word(afcr_pkg::CMD_SAMPLE, 32'hA5A5_5A5A, 2);
		// length change mid-frame waits for the next frame start
		drain_and_settle();
		write_reg(afcr_pkg::CFG_FIXED_LENGTH, 20'd3);
		push_word(afcr_pkg::CMD_SAMPLE, 32'h1234_5678, 0);
		push_word(afcr_pkg::CMD_SAMPLE, 32'h8765_4321, 0);
		drain_and_settle();
		write_reg(afcr_pkg::CFG_FIXED_LENGTH, 20'd2);
		push_word(afcr_pkg::CMD_SAMPLE, 32'h0F0F_0F0F, 0);
		push_word(afcr_pkg::CMD_SAMPLE, 32'hF0F0_F0F0, 0);
		push_word(afcr_pkg::CMD_SAMPLE, 32'h5555_AAAA, 0);
		// restart inside a frame
		push_word(afcr_pkg::CMD_SAMPLE, 32'hDEAD_BEEF, 0);
		push_word(afcr_pkg::CMD_RESTART, 32'hFFFF_FFFF, 0);
		push_word(afcr_pkg::CMD_SAMPLE, 32'hCAFE_F00D, 0);
		// largest fixed length
		drain_and_settle();
		write_reg(afcr_pkg::CFG_FIXED_LENGTH, 20'hFFFFF);
		push_word(afcr_pkg::CMD_SAMPLE, 32'h0000_0001, 0);
		push_word(afcr_pkg::CMD_SAMPLE, 32'h8000_0000, 0);
		// saturated derived length and saturated remainder
		drain_and_settle();
		write_all('0, 20'hFFFFF, 20'd1000, 20'd1001);
		push_word(afcr_pkg::CMD_RESTART, 32'h0, 0);
		push_word(afcr_pkg::CMD_SAMPLE, 32'h7FFF_FFFF, 0);
		// zero numerator
		drain_and_settle();
		write_reg(afcr_pkg::CFG_RATE_NUM, 20'd0);
		push_word(afcr_pkg::CMD_RESTART, 32'h0, 0);
		push_word(afcr_pkg::CMD_SAMPLE, 32'h3C3C_C3C3, 0);
		// zero derived length forced up to two, remainder clamped at zero
		drain_and_settle();
		write_all('0, 20'd8000, 20'd120000, 20'd0);
		push_word(afcr_pkg::CMD_RESTART, 32'h0, 0);
		push_word(afcr_pkg::CMD_SAMPLE, 32'h0000_FFFF, 0);
		push_word(afcr_pkg::CMD_SAMPLE, 32'hFFFF_0000, 3);
		push_word(afcr_pkg::CMD_SAMPLE, 32'h6969_9696, 0);

		// random phases, the first one a deliberate output stall
		target = words_queued + RANDOM_ITEMS;
		run_phase(PH_BACKPRESSURE);
		while (words_queued < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2:  kind = PH_FIXED_SHORT;
				3, 4, 5:  kind = PH_DERIVED_SHORT;
				6:        kind = PH_VIDEO_RATE;
				7, 8:     kind = PH_RAW_REGS;
				default:  kind = PH_BACKPRESSURE;
			endcase
			run_phase(kind);
		end

		drain_and_settle();
		$display("Covered %0d sample words and %0d restarts over %0d random phases",
			samples_seen, restarts_seen, phases_run);
		$display("%0d frames closed, %0d register writes", frames_closed, regs_written);
		if (mismatches == 0)
			$display("audio_frame_cadence_rechunker test passed");
		else
			$display("audio_frame_cadence_rechunker test failed");
		$finish;
	end

	// Watchdog
	initial begin
		#20000000;
		$display("audio_frame_cadence_rechunker test failed");
		$finish;
	end

endmodule
